[hw/rtl/atrlc_pkg.sv]
package atrlc_pkg;

   localparam int LINE_MAX   = 50;
   localparam int LINE_CAP   = LINE_MAX - 1;
   localparam int CNT_W      = $clog2(LINE_MAX);
   localparam int IDX_W      = $clog2(LINE_CAP);
   localparam int STORE_DEPTH = 2 * LINE_CAP;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int LEN_W      = 6;
   localparam int NUM_PREFIX = 6;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef logic [2:0] class_type;

   localparam class_type CLS_AT    = 3'd0;
   localparam class_type CLS_OK    = 3'd1;
   localparam class_type CLS_ERROR = 3'd2;
   localparam class_type CLS_CGSN  = 3'd3;
   localparam class_type CLS_CGMR  = 3'd4;
   localparam class_type CLS_CPIN  = 3'd5;
   localparam class_type CLS_NONE  = 3'd6;

   typedef struct packed {
      class_type        cls;
      logic [LEN_W-1:0] len;
      logic             last;
   } meta_type;

   // prefix length, sized to the fill counter
   function automatic logic [CNT_W-1:0] pfx_len(input class_type idx);
      logic [CNT_W-1:0] r;
      case (idx)
         CLS_AT:    r = CNT_W'(2);
         CLS_OK:    r = CNT_W'(2);
         CLS_ERROR: r = CNT_W'(5);
         CLS_CGSN:  r = CNT_W'(6);
         CLS_CGMR:  r = CNT_W'(6);
         CLS_CPIN:  r = CNT_W'(6);
         default:   r = '0;
      endcase
      return r;
   endfunction

   // prefix text, one character at a position
   function automatic logic [7:0] pfx_char(input class_type idx, input logic [2:0] pos);
      logic [47:0] txt;
      logic [7:0]  r;
      case (idx)
         CLS_AT:    txt = {"AT", 32'h0};
         CLS_OK:    txt = {"OK", 32'h0};
         CLS_ERROR: txt = {"ERROR", 8'h0};
         CLS_CGSN:  txt = "+CGSN:";
         CLS_CGMR:  txt = "+CGMR:";
         CLS_CPIN:  txt = "+CPIN:";
         default:   txt = '0;
      endcase
      case (pos)
         3'd0:    r = txt[47:40];
         3'd1:    r = txt[39:32];
         3'd2:    r = txt[31:24];
         3'd3:    r = txt[23:16];
         3'd4:    r = txt[15:8];
         3'd5:    r = txt[7:0];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/at_response_line_classifier.sv]
// Modem response line classifier.
// Request channel (req_valid/req_ready/req_rx_byte) takes one received byte
// per request. CR or LF ends a line; other bytes are stored, up to LINE_MAX-1
// of them. A byte beyond that discards the line held so far and is dropped.
// An empty line yields nothing.
// Response channel (rsp_valid/rsp_ready/rsp_*) gives one character of a
// completed line per cycle while not stalled, with its prefix class, the
// line length and a last flag on the final character.
// Throughput: one request per cycle while req_ready is high, and one
// response per cycle while a line drains and rsp_ready is high. The line store
// is a two-bank RAM: one bank fills while the other drains, so bytes of the
// next line keep flowing during a drain. After a terminator is taken, the first
// character is read into the RAM read register, then loaded into the output register.
// A terminator that closes a non-empty line is held off (req_ready low) while
// the drain bank is still issuing reads of the previous line; a receiver stall
// lengthens that wait.
// Receiver stall: the output register and the RAM read register both hold,
// and no further read is issued until one of them frees.
// Reset: synchronous; clears the fill count, fill bank select and all valid
// flags, and sets every prefix flag. The RAM is not cleared: only entries of the current line are read.
module at_response_line_classifier
   import atrlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_line_char,
   output class_type  rsp_line_class,
   output logic [LEN_W-1:0] rsp_line_length,
   output logic       rsp_last_of_line
);

   // fill side
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [NUM_PREFIX-1:0] alive_ff, alive_in;
   logic                  fill_bank_ff, fill_bank_in;

   // drain side
   logic                  drain_active_ff, drain_active_in;
   logic                  drain_bank_ff, drain_bank_in;
   logic [CNT_W-1:0]      drain_len_ff, drain_len_in;
   class_type             drain_cls_ff, drain_cls_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;

   // read register stage
   logic                  rd_pend_ff, rd_pend_in;
   meta_type              meta_q_ff, meta_q_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff;
   meta_type              rsp_meta_ff;

   logic                  req_take, is_term, handoff, fill_room;
   class_type             line_cls;
   logic                  out_load, q_free, rd_en, rd_last;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [7:0]            rd_data;
   logic [CNT_W+LEN_W-1:0] len_wide;

   assign is_term   = (req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF);
   // hold a line-closing terminator until the drain bank is free
   assign req_ready = !(is_term && (fill_ff != '0) && drain_active_ff);
   assign req_take  = req_valid && req_ready;
   assign handoff   = req_take && is_term && (fill_ff != '0);
   assign fill_room = fill_ff < CNT_W'(LINE_CAP);

   // first live prefix that the line is long enough for
   always_comb begin
      line_cls = CLS_NONE;
      for (int i = NUM_PREFIX - 1; i >= 0; i--) begin
         if (alive_ff[i] && (fill_ff >= pfx_len(class_type'(i)))) begin
            line_cls = class_type'(i);
         end
      end
   end

   // fill-side next state
   always_comb begin
      fill_in      = fill_ff;
      alive_in     = alive_ff;
      fill_bank_in = fill_bank_ff;
      wr_en        = 1'b0;
      if (req_take) begin
         if (is_term) begin
            if (handoff) begin
               fill_bank_in = !fill_bank_ff;
            end
            fill_in  = '0;
            alive_in = '1;
         end else if (fill_room) begin
            wr_en   = 1'b1;
            fill_in = fill_ff + CNT_W'(1);
            for (int i = 0; i < NUM_PREFIX; i++) begin
               if ((fill_ff < pfx_len(class_type'(i))) &&
                   (pfx_char(class_type'(i), fill_ff[2:0]) != req_rx_byte)) begin
                  alive_in[i] = 1'b0;
               end
            end
         end else begin
            // overflow: drop the byte and the line held so far
            fill_in  = '0;
            alive_in = '1;
         end
      end
   end

   assign wr_addr = fill_bank_ff ? ADDR_W'(LINE_CAP) + ADDR_W'(fill_ff)
                                 : ADDR_W'(fill_ff);

   // drain side: one read per cycle while the read register can move on
   assign out_load = rd_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign q_free   = !rd_pend_ff || out_load;
   assign rd_en    = drain_active_ff && q_free;
   assign rd_last  = (rd_idx_ff + CNT_W'(1)) == drain_len_ff;
   assign rd_addr  = drain_bank_ff ? ADDR_W'(LINE_CAP) + ADDR_W'(rd_idx_ff)
                                   : ADDR_W'(rd_idx_ff);
   assign len_wide = {{LEN_W{1'b0}}, drain_len_ff};

   always_comb begin
      drain_active_in = drain_active_ff;
      drain_bank_in   = drain_bank_ff;
      drain_len_in    = drain_len_ff;
      drain_cls_in    = drain_cls_ff;
      rd_idx_in       = rd_idx_ff;
      rd_pend_in      = rd_pend_ff;
      meta_q_in       = meta_q_ff;
      if (out_load) begin
         rd_pend_in = 1'b0;
      end
      if (rd_en) begin
         rd_pend_in     = 1'b1;
         meta_q_in.cls  = drain_cls_ff;
         meta_q_in.len  = len_wide[LEN_W-1:0];
         meta_q_in.last = rd_last;
         rd_idx_in      = rd_idx_ff + CNT_W'(1);
         if (rd_last) begin
            drain_active_in = 1'b0;
         end
      end
      if (handoff) begin
         drain_active_in = 1'b1;
         drain_bank_in   = fill_bank_ff;
         drain_len_in    = fill_ff;
         drain_cls_in    = line_cls;
         rd_idx_in       = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   atrlc_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         alive_ff        <= '1;
         fill_bank_ff    <= 1'b0;
         drain_active_ff <= 1'b0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         alive_ff        <= alive_in;
         fill_bank_ff    <= fill_bank_in;
         drain_active_ff <= drain_active_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      drain_bank_ff <= drain_bank_in;
      drain_len_ff  <= drain_len_in;
      drain_cls_ff  <= drain_cls_in;
      rd_idx_ff     <= rd_idx_in;
      meta_q_ff     <= meta_q_in;
      if (out_load) begin
         rsp_char_ff <= rd_data;
         rsp_meta_ff <= meta_q_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_char    = rsp_char_ff;
   assign rsp_line_class   = rsp_meta_ff.cls;
   assign rsp_line_length  = rsp_meta_ff.len;
   assign rsp_last_of_line = rsp_meta_ff.last;

`ifndef SYNTHESIS
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(LINE_CAP))
      else $error("fill count beyond line capacity");

   a_handoff_idle : assert property (@(posedge clock) disable iff (reset)
      handoff |-> !drain_active_ff)
      else $error("line handed off while drain still busy");

   a_bank_apart : assert property (@(posedge clock) disable iff (reset)
      drain_active_ff |-> (drain_bank_ff != fill_bank_ff))
      else $error("drain and fill share a bank");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && !out_load) |=> $stable(meta_q_ff) && rd_pend_ff)
      else $error("read register overwritten before it moved on");
`endif

endmodule

[hw/rtl/atrlc_ram.sv]
module atrlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
